// ===== sv/rsit_pkg.sv =====
// shared widths, codes, stage records and step functions for the ray-sphere time pipeline
package rsit_pkg;

  localparam int POS_W      = 48;
  localparam int VEL_W      = 32;
  localparam int VEL_FRAC   = 30;
  localparam int MAG_W      = 49;
  localparam int HT_W       = 81;
  localparam int SQT_W      = 98;
  localparam int H_W        = 84;
  localparam int HM_W       = 83;
  localparam int C_W        = 101;
  localparam int CM_W       = 100;
  localparam int A_W        = 64;
  localparam int HSQ_W      = 166;
  localparam int AC_W       = 164;
  localparam int D_W        = 168;
  localparam int SQ_STEPS   = 83;
  localparam int ROOT_W     = 83;
  localparam int REM_W      = 85;
  localparam int N_W        = 86;
  localparam int NM_W       = 85;
  localparam int U_W        = 116;
  localparam int QBITS      = 48;
  localparam int FIFO_AW    = 8;
  localparam int FIFO_DEPTH = 256;

  typedef logic [1:0] status_t;
  localparam status_t ST_HIT   = 2'd0;
  localparam status_t ST_MISS  = 2'd1;
  localparam status_t ST_DEGEN = 2'd2;

  localparam logic [POS_W-1:0] RADIUS_RESET = POS_W'(64'd16777216);
  localparam logic [QBITS-1:0] LIMIT_POS    = {1'b0, {(QBITS-1){1'b1}}};
  localparam logic [QBITS-1:0] LIMIT_NEG    = {1'b1, {(QBITS-1){1'b0}}};

  // square root stage record
  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
    logic [HSQ_W-1:0]      dsh;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
    logic                  sel_max;
    status_t               status;
  } sq_t;

  // divider stage record
  typedef struct packed {
    logic [A_W-1:0]   rem;
    logic [QBITS-1:0] q;
    logic [QBITS-1:0] ush;
    logic [A_W-1:0]   a;
    logic             neg;
    logic             sat;
    status_t          status;
  } dv_t;

  function automatic logic [MAG_W-1:0] abs_pos(input logic signed [MAG_W-1:0] x);
    return x[MAG_W-1] ? MAG_W'(-x) : MAG_W'(x);
  endfunction

  function automatic logic [VEL_W-1:0] abs_vel(input logic signed [VEL_W-1:0] x);
    return x[VEL_W-1] ? VEL_W'(-x) : VEL_W'(x);
  endfunction

  // one result bit of the digit-by-digit square root
  function automatic sq_t sq_step(input sq_t c);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    logic             ge;
    sq_t              n;
    t     = {c.rem, c.dsh[HSQ_W-1 -: 2]};
    trial = {2'b00, c.root, 2'b01};
    ge    = (t >= trial);
    n       = c;
    n.rem   = ge ? REM_W'(t - trial) : REM_W'(t);
    n.root  = {c.root[ROOT_W-2:0], ge};
    n.dsh   = c.dsh << 2;
    return n;
  endfunction

  // one quotient bit of the restoring divider
  function automatic dv_t dv_step(input dv_t c);
    logic [A_W:0] t;
    logic         ge;
    dv_t          n;
    t     = {c.rem, c.ush[QBITS-1]};
    ge    = (t >= {1'b0, c.a});
    n     = c;
    n.rem = ge ? A_W'(t - {1'b0, c.a}) : t[A_W-1:0];
    n.q   = {c.q[QBITS-2:0], ge};
    n.ush = c.ush << 1;
    return n;
  endfunction

endpackage

// ===== sv/ray_sphere_intersect_time_top.sv =====
// ray-sphere intersection time: fixed-point pipeline with output queue
//
// One ray per input beat (pos_x/y/z Q24.24, vel_x/y/z Q2.30) on in_valid/in_ready;
// one result beat (status, hit_time Q24.24) per ray on out_valid/out_ready, in order.
// The radius register is written through cfg_valid/cfg_ready/radius, which is always
// ready; write it only while no ray is in flight.
// Throughput is one ray per cycle while in_ready is high; from input beat to the
// output queue the datapath is 11 arithmetic stages, 83 square root stages (one root
// bit each), 3 stages forming the dividend, and 48 divider stages (one quotient bit
// each), and the queue then feeds the output register.
// The datapath never stalls; results land in a 256-entry queue and in_ready drops
// only when 256 rays are accepted and not yet delivered, so a stalled receiver
// backs up the queue and then the input, losing nothing.
// Synchronous reset empties the pipeline and queue and sets radius to 1.0.
module ray_sphere_intersect_time_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [rsit_pkg::POS_W-1:0] pos_x,
  input  logic signed [rsit_pkg::POS_W-1:0] pos_y,
  input  logic signed [rsit_pkg::POS_W-1:0] pos_z,
  input  logic signed [rsit_pkg::VEL_W-1:0] vel_x,
  input  logic signed [rsit_pkg::VEL_W-1:0] vel_y,
  input  logic signed [rsit_pkg::VEL_W-1:0] vel_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic signed [rsit_pkg::QBITS-1:0] hit_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic signed [rsit_pkg::POS_W-1:0] radius
);
  import rsit_pkg::*;

  logic [POS_W-1:0] sphere_radius;
  logic             in_acc;
  logic             out_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sphere_radius <= radius;
    end
  end

  // stage 1: capture beat
  logic                    s1_v;
  logic signed [POS_W-1:0] s1_px, s1_py, s1_pz, s1_r;
  logic signed [VEL_W-1:0] s1_vx, s1_vy, s1_vz;

  always_ff @(posedge clk) begin
    s1_px <= pos_x;
    s1_py <= pos_y;
    s1_pz <= pos_z;
    s1_vx <= vel_x;
    s1_vy <= vel_y;
    s1_vz <= vel_z;
    s1_r  <= sphere_radius;
  end

  // stage 2: z0 and magnitudes
  logic                    s2_v;
  logic signed [MAG_W-1:0] s2_z0;
  logic [MAG_W-1:0]        s2_pm [0:3];
  logic [VEL_W-1:0]        s2_vm [0:2];
  logic                    s2_ps [0:1];
  logic                    s2_vs [0:2];
  logic                    s2_sel;

  always_ff @(posedge clk) begin
    s2_z0    <= {s1_pz[POS_W-1], s1_pz} - {s1_r[POS_W-1], s1_r};
    s2_pm[0] <= abs_pos({s1_px[POS_W-1], s1_px});
    s2_pm[1] <= abs_pos({s1_py[POS_W-1], s1_py});
    s2_pm[2] <= '0;
    s2_pm[3] <= abs_pos({s1_r[POS_W-1], s1_r});
    s2_ps[0] <= s1_px[POS_W-1];
    s2_ps[1] <= s1_py[POS_W-1];
    s2_vm[0] <= abs_vel(s1_vx);
    s2_vm[1] <= abs_vel(s1_vy);
    s2_vm[2] <= abs_vel(s1_vz);
    s2_vs[0] <= s1_vx[VEL_W-1];
    s2_vs[1] <= s1_vy[VEL_W-1];
    s2_vs[2] <= s1_vz[VEL_W-1];
    s2_sel   <= (s1_vz != '0) && (s1_r != '0) && (s1_vz[VEL_W-1] != s1_r[POS_W-1]);
  end

  // stage 3: magnitude of z0
  logic             s3_v;
  logic [MAG_W-1:0] s3_pm [0:3];
  logic             s3_ps [0:2];
  logic [VEL_W-1:0] s3_vm [0:2];
  logic             s3_vs [0:2];
  logic             s3_sel;

  always_ff @(posedge clk) begin
    s3_pm[0] <= s2_pm[0];
    s3_pm[1] <= s2_pm[1];
    s3_pm[2] <= abs_pos(s2_z0);
    s3_pm[3] <= s2_pm[3];
    s3_ps[0] <= s2_ps[0];
    s3_ps[1] <= s2_ps[1];
    s3_ps[2] <= s2_z0[MAG_W-1];
    s3_vm    <= s2_vm;
    s3_vs    <= s2_vs;
    s3_sel   <= s2_sel;
  end

  // stage 4: partial products
  logic                 s4_v;
  logic [63:0]          s4_hl [0:2];
  logic [48:0]          s4_hh [0:2];
  logic                 s4_hs [0:2];
  logic [63:0]          s4_ql [0:3];
  logic [48:0]          s4_qm [0:3];
  logic [33:0]          s4_qh [0:3];
  logic [63:0]          s4_al [0:2];
  logic                 s4_sel;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      s4_hl[j] <= s3_vm[j] * s3_pm[j][31:0];
      s4_hh[j] <= s3_vm[j] * s3_pm[j][MAG_W-1:32];
      s4_hs[j] <= s3_vs[j] ^ s3_ps[j];
      s4_al[j] <= s3_vm[j] * s3_vm[j];
    end
    for (int j = 0; j < 4; j++) begin
      s4_ql[j] <= s3_pm[j][31:0] * s3_pm[j][31:0];
      s4_qm[j] <= s3_pm[j][31:0] * s3_pm[j][MAG_W-1:32];
      s4_qh[j] <= s3_pm[j][MAG_W-1:32] * s3_pm[j][MAG_W-1:32];
    end
    s4_sel <= s3_sel;
  end

  // stage 5: assemble product terms
  logic              s5_v;
  logic [HT_W-1:0]   s5_ht [0:2];
  logic              s5_hs [0:2];
  logic [SQT_W-1:0]  s5_q  [0:3];
  logic [A_W-1:0]    s5_a;
  logic              s5_sel;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      s5_ht[j] <= HT_W'(s4_hl[j]) + (HT_W'(s4_hh[j]) << 32);
      s5_hs[j] <= s4_hs[j];
    end
    for (int j = 0; j < 4; j++) begin
      s5_q[j] <= SQT_W'(s4_ql[j]) + (SQT_W'(s4_qm[j]) << 33) + (SQT_W'(s4_qh[j]) << 64);
    end
    s5_a   <= s4_al[0] + s4_al[1] + s4_al[2];
    s5_sel <= s4_sel;
  end

  // stage 6: half-b and c as signed sums
  logic                  s6_v;
  logic signed [H_W-1:0] s6_h;
  logic signed [C_W-1:0] s6_c;
  logic [A_W-1:0]        s6_a;
  logic                  s6_sel;
  logic signed [H_W-1:0] hterm [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hterm[j] = s5_hs[j] ? -$signed({3'b000, s5_ht[j]}) : $signed({3'b000, s5_ht[j]});
    end
  end

  always_ff @(posedge clk) begin
    s6_h   <= hterm[0] + hterm[1] + hterm[2];
    s6_c   <= $signed({3'b000, s5_q[0]}) + $signed({3'b000, s5_q[1]})
            + $signed({3'b000, s5_q[2]}) - $signed({3'b000, s5_q[3]});
    s6_a   <= s5_a;
    s6_sel <= s5_sel;
  end

  // stage 7: magnitudes and flags
  logic                  s7_v;
  logic signed [H_W-1:0] s7_h;
  logic [HM_W-1:0]       s7_hm;
  logic [CM_W-1:0]       s7_cm;
  logic                  s7_cneg, s7_hle0, s7_czero, s7_azero;
  logic [A_W-1:0]        s7_a;
  logic                  s7_sel;

  always_ff @(posedge clk) begin
    s7_h     <= s6_h;
    s7_hm    <= s6_h[H_W-1] ? HM_W'(-s6_h) : HM_W'(s6_h);
    s7_cm    <= s6_c[C_W-1] ? CM_W'(-s6_c) : CM_W'(s6_c);
    s7_cneg  <= s6_c[C_W-1];
    s7_hle0  <= s6_h[H_W-1] || (s6_h == '0);
    s7_czero <= (s6_c == '0);
    s7_azero <= (s6_a == '0);
    s7_a     <= s6_a;
    s7_sel   <= s6_sel;
  end

  // stage 8: partial products of h^2 and a*c
  logic                  s8_v;
  logic [63:0]           s8_p00, s8_p11, s8_p01;
  logic [37:0]           s8_p22;
  logic [50:0]           s8_p02, s8_p12;
  logic [63:0]           s8_x00, s8_x01, s8_x10, s8_x11, s8_x02, s8_x12;
  logic [35:0]           s8_x03, s8_x13;
  logic signed [H_W-1:0] s8_h;
  logic [A_W-1:0]        s8_a;
  logic                  s8_cneg, s8_hle0, s8_czero, s8_azero, s8_sel;

  always_ff @(posedge clk) begin
    s8_p00   <= s7_hm[31:0]  * s7_hm[31:0];
    s8_p11   <= s7_hm[63:32] * s7_hm[63:32];
    s8_p22   <= s7_hm[HM_W-1:64] * s7_hm[HM_W-1:64];
    s8_p01   <= s7_hm[31:0]  * s7_hm[63:32];
    s8_p02   <= s7_hm[31:0]  * s7_hm[HM_W-1:64];
    s8_p12   <= s7_hm[63:32] * s7_hm[HM_W-1:64];
    s8_x00   <= s7_a[31:0]  * s7_cm[31:0];
    s8_x01   <= s7_a[31:0]  * s7_cm[63:32];
    s8_x10   <= s7_a[63:32] * s7_cm[31:0];
    s8_x11   <= s7_a[63:32] * s7_cm[63:32];
    s8_x02   <= s7_a[31:0]  * s7_cm[95:64];
    s8_x12   <= s7_a[63:32] * s7_cm[95:64];
    s8_x03   <= s7_a[31:0]  * s7_cm[CM_W-1:96];
    s8_x13   <= s7_a[63:32] * s7_cm[CM_W-1:96];
    s8_h     <= s7_h;
    s8_a     <= s7_a;
    s8_cneg  <= s7_cneg;
    s8_hle0  <= s7_hle0;
    s8_czero <= s7_czero;
    s8_azero <= s7_azero;
    s8_sel   <= s7_sel;
  end

  // stage 9: partial sums
  logic                  s9_v;
  logic [HSQ_W-1:0]      s9_hlo, s9_hhi;
  logic [AC_W-1:0]       s9_xlo, s9_xhi;
  logic signed [H_W-1:0] s9_h;
  logic [A_W-1:0]        s9_a;
  logic                  s9_cneg, s9_hle0, s9_czero, s9_azero, s9_sel;

  always_ff @(posedge clk) begin
    s9_hlo   <= HSQ_W'(s8_p00) + (HSQ_W'(s8_p01) << 33) + (HSQ_W'(s8_p11) << 64);
    s9_hhi   <= (HSQ_W'(s8_p02) << 65) + (HSQ_W'(s8_p12) << 97) + (HSQ_W'(s8_p22) << 128);
    s9_xlo   <= AC_W'(s8_x00) + (AC_W'(s8_x01) << 32) + (AC_W'(s8_x10) << 32)
              + (AC_W'(s8_x11) << 64);
    s9_xhi   <= (AC_W'(s8_x02) << 64) + (AC_W'(s8_x12) << 96) + (AC_W'(s8_x03) << 96)
              + (AC_W'(s8_x13) << 128);
    s9_h     <= s8_h;
    s9_a     <= s8_a;
    s9_cneg  <= s8_cneg;
    s9_hle0  <= s8_hle0;
    s9_czero <= s8_czero;
    s9_azero <= s8_azero;
    s9_sel   <= s8_sel;
  end

  // stage 10: h^2 and a*|c|
  logic                  s10_v;
  logic [HSQ_W-1:0]      s10_hsq;
  logic [AC_W-1:0]       s10_ac;
  logic signed [H_W-1:0] s10_h;
  logic [A_W-1:0]        s10_a;
  logic                  s10_cneg, s10_hle0, s10_czero, s10_azero, s10_sel;

  always_ff @(posedge clk) begin
    s10_hsq   <= s9_hlo + s9_hhi;
    s10_ac    <= s9_xlo + s9_xhi;
    s10_h     <= s9_h;
    s10_a     <= s9_a;
    s10_cneg  <= s9_cneg;
    s10_hle0  <= s9_hle0;
    s10_czero <= s9_czero;
    s10_azero <= s9_azero;
    s10_sel   <= s9_sel;
  end

  // stage 11: discriminant, status, square root setup
  logic signed [D_W-1:0] disc;
  logic signed [D_W-1:0] ac_s;
  sq_t                   sq_in;

  always_comb begin
    ac_s = $signed({4'b0000, s10_ac});
    disc = $signed({2'b00, s10_hsq}) - (s10_cneg ? -ac_s : ac_s);
    sq_in         = '0;
    sq_in.dsh     = disc[HSQ_W-1:0];
    sq_in.h       = s10_h;
    sq_in.a       = s10_a;
    sq_in.sel_max = s10_sel;
    if (disc[D_W-1]) begin
      sq_in.status = ST_MISS;
    end else if (s10_azero || (s10_hle0 && s10_czero)) begin
      sq_in.status = ST_DEGEN;
    end else begin
      sq_in.status = ST_HIT;
    end
  end

  // square root stages, one root bit each
  sq_t  sq  [0:SQ_STEPS];
  logic sqv [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    sq[0] <= sq_in;
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    always_ff @(posedge clk) begin
      sq[i+1] <= sq_step(sq[i]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[i+1] <= 1'b0;
      end else begin
        sqv[i+1] <= sqv[i];
      end
    end
  end

  // root pick: n = -h +/- s
  logic                  n_v;
  logic signed [N_W-1:0] n_val;
  logic [A_W-1:0]        n_a;
  status_t               n_status;
  logic signed [N_W-1:0] nh;
  logic signed [N_W-1:0] ns;

  always_comb begin
    nh = -$signed({{(N_W-H_W){sq[SQ_STEPS].h[H_W-1]}}, sq[SQ_STEPS].h});
    ns = $signed({{(N_W-ROOT_W){1'b0}}, sq[SQ_STEPS].root});
  end

  always_ff @(posedge clk) begin
    n_val    <= sq[SQ_STEPS].sel_max ? (nh + ns) : (nh - ns);
    n_a      <= sq[SQ_STEPS].a;
    n_status <= sq[SQ_STEPS].status;
  end

  // dividend with rounding half of a
  logic           u_v;
  logic [U_W-1:0] u_val;
  logic [A_W-1:0] u_a;
  logic           u_neg;
  status_t        u_status;

  always_ff @(posedge clk) begin
    u_val    <= (U_W'(n_val[N_W-1] ? NM_W'(-n_val) : NM_W'(n_val)) << VEL_FRAC)
              + U_W'(n_a >> 1);
    u_a      <= n_a;
    u_neg    <= n_val[N_W-1];
    u_status <= n_status;
  end

  // divider setup and saturation test
  dv_t  dv  [0:QBITS];
  logic dvv [0:QBITS];
  dv_t  dv_in;

  always_comb begin
    dv_in        = '0;
    dv_in.sat    = (u_val >= (U_W'(u_a) << QBITS));
    dv_in.rem    = A_W'(u_val >> QBITS);
    dv_in.ush    = u_val[QBITS-1:0];
    dv_in.a      = u_a;
    dv_in.neg    = u_neg;
    dv_in.status = u_status;
  end

  always_ff @(posedge clk) begin
    dv[0] <= dv_in;
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    always_ff @(posedge clk) begin
      dv[i+1] <= dv_step(dv[i]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[i+1] <= 1'b0;
      end else begin
        dvv[i+1] <= dvv[i];
      end
    end
  end

  // front-end valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      s3_v   <= 1'b0;
      s4_v   <= 1'b0;
      s5_v   <= 1'b0;
      s6_v   <= 1'b0;
      s7_v   <= 1'b0;
      s8_v   <= 1'b0;
      s9_v   <= 1'b0;
      s10_v  <= 1'b0;
      sqv[0] <= 1'b0;
      n_v    <= 1'b0;
      u_v    <= 1'b0;
      dvv[0] <= 1'b0;
    end else begin
      s1_v   <= in_acc;
      s2_v   <= s1_v;
      s3_v   <= s2_v;
      s4_v   <= s3_v;
      s5_v   <= s4_v;
      s6_v   <= s5_v;
      s7_v   <= s6_v;
      s8_v   <= s7_v;
      s9_v   <= s8_v;
      s10_v  <= s9_v;
      sqv[0] <= s10_v;
      n_v    <= sqv[SQ_STEPS];
      u_v    <= n_v;
      dvv[0] <= u_v;
    end
  end

  // clamp, sign and status masking
  logic [QBITS-1:0] limit;
  logic [QBITS-1:0] mag;
  logic [QBITS-1:0] tval;
  logic             fifo_we;

  always_comb begin
    limit = dv[QBITS].neg ? LIMIT_NEG : LIMIT_POS;
    mag   = (dv[QBITS].sat || (dv[QBITS].q > limit)) ? limit : dv[QBITS].q;
    tval  = dv[QBITS].neg ? -mag : mag;
    if (dv[QBITS].status != ST_HIT) begin
      tval = '0;
    end
  end

  assign fifo_we = dvv[QBITS];

  // result queue
  logic [QBITS+1:0]   qmem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   fcnt, occ;
  logic               load;

  assign load     = (fcnt != '0) && (!out_valid || out_ready);
  assign in_ready = (occ != (FIFO_AW+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      qmem[wr_ptr] <= {dv[QBITS].status, tval};
    end
    if (load) begin
      {status, hit_time} <= qmem[rd_ptr];
    end
  end

  // queue pointers, fill and in-flight counts
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      fcnt      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fifo_we) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fcnt <= fcnt + (FIFO_AW+1)'(fifo_we) - (FIFO_AW+1)'(load);
      occ  <= occ + (FIFO_AW+1)'(in_acc) - (FIFO_AW+1)'(out_acc);
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("in-flight count over queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_we |-> (fcnt != (FIFO_AW+1)'(FIFO_DEPTH))) else $error("queue write while full");

  a_time_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_HIT)) |-> (hit_time == '0))
    else $error("nonzero time on miss or degenerate beat");

  a_out_owned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occ != '0)) else $error("result beat with no ray in flight");

endmodule

// ===== dv/tb_ray_sphere_intersect_time_top.sv =====
// self-checking testbench for the ray-sphere intersection time pipeline
module tb_ray_sphere_intersect_time_top;
  import rsit_pkg::*;

  localparam int MAX_IDLE    = 13;
  localparam int DRAIN       = 200;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic signed [47:0] ONE = 48'sd16777216;
  localparam logic signed [31:0] VONE = 32'sd1073741824;
  localparam logic signed [47:0] PMAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] PMIN = {1'b1, {47{1'b0}}};
  localparam logic signed [31:0] VMAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] VMIN = {1'b1, {31{1'b0}}};

  typedef struct {
    logic signed [47:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
  } ray_t;

  typedef struct {
    status_t     status;
    logic [47:0] hit_time;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic in_ready, out_valid, cfg_ready;
  logic signed [47:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [47:0] cfg_radius = '0;
  logic [1:0] status;
  logic signed [47:0] hit_time;

  ray_t pending_rays[$];
  hit_t expected_hits[$];
  logic signed [47:0] model_radius = ONE;
  logic hold_rays = 1'b0;
  int   in_gap = 0, out_stall = 0, errors = 0, cycles = 0;
  logic in_burst = 1'b0, out_burst = 1'b0;

  ray_sphere_intersect_time_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .hit_time(hit_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .radius(cfg_radius)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // exact intersection time of one ray against the current sphere
  function automatic hit_t intersect_time(ray_t r, logic signed [47:0] rad);
    logic signed [255:0] px, py, pz, vx, vy, vz, rr, z0, h, c, a, d, n;
    logic [255:0] root, cand, num, quo, lim, div;
    logic sel_far;
    hit_t e;
    px = r.pos_x; py = r.pos_y; pz = r.pos_z;
    vx = r.vel_x; vy = r.vel_y; vz = r.vel_z; rr = rad;
    z0 = pz - rr;
    h = vz * z0 + vx * px + vy * py;
    c = z0 * z0 - rr * rr + px * px + py * py;
    a = vx * vx + vy * vy + vz * vz;
    d = h * h - a * c;
    e.status = ST_HIT;
    e.hit_time = '0;
    if (d < 0) begin
      e.status = ST_MISS;
    end else if (a == 0 || (h <= 0 && c == 0)) begin
      e.status = ST_DEGEN;
    end else begin
      // floor square root, one bit at a time
      root = '0;
      for (int b = 99; b >= 0; b--) begin
        cand = root | (256'd1 << b);
        if (cand * cand <= d) root = cand;
      end
      sel_far = (vz != 0) && (rr != 0) && ((vz < 0) != (rr < 0));
      n = sel_far ? -h + $signed(root) : -h - $signed(root);
      div = a;
      num = ((n < 0) ? -n : n);
      num = (num << VEL_FRAC) + (div >> 1);
      quo = num / div;
      lim = (n < 0) ? (256'd1 << 47) : ((256'd1 << 47) - 1);
      if (quo > lim) quo = lim;
      e.hit_time = (n < 0) ? -quo[47:0] : quo[47:0];
    end
    return e;
  endfunction

  function automatic ray_t make_ray(logic signed [47:0] px, py, pz,
                                    logic signed [31:0] vx, vy, vz);
    ray_t r;
    r.pos_x = px; r.pos_y = py; r.pos_z = pz;
    r.vel_x = vx; r.vel_y = vy; r.vel_z = vz;
    return r;
  endfunction

  function automatic logic signed [47:0] any_pos();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic signed [47:0] near_pos(int span);
    return $signed(48'($urandom_range(0, 2 * span))) - span;
  endfunction

  // mostly rays aimed at the sphere region, the rest noise over full range
  function automatic ray_t random_ray();
    ray_t r;
    if ($urandom_range(0, 4) == 0) begin
      r = make_ray(any_pos(), any_pos(), any_pos(), $urandom(), $urandom(), $urandom());
    end else begin
      r.pos_x = near_pos(1 << 25);
      r.pos_y = near_pos(1 << 25);
      r.pos_z = near_pos(1 << 27);
      r.vel_x = $signed(32'($urandom_range(0, 1 << 29))) - (1 << 28);
      r.vel_y = $signed(32'($urandom_range(0, 1 << 29))) - (1 << 28);
      r.vel_z = $urandom_range(0, 1) ? VONE - $urandom_range(0, 1 << 28)
                                     : -VONE + $urandom_range(0, 1 << 28);
    end
    return r;
  endfunction

  function automatic int draw_idle(logic burst);
    return burst ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // ray driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_hits.push_back(intersect_time(make_ray(pos_x, pos_y, pos_z,
                                                        vel_x, vel_y, vel_z),
                                               model_radius));
        if ($urandom_range(0, 15) == 0) in_burst <= !in_burst;
      end
      if ((in_valid && in_ready) || !in_valid) begin
        if (!in_valid && in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (in_valid && draw_idle(in_burst) > 0) begin
          in_valid <= 1'b0;
          in_gap <= draw_idle(1'b0);
        end else if (pending_rays.size() > 0 && !hold_rays) begin
          ray_t r;
          r = pending_rays.pop_front();
          pos_x <= r.pos_x; pos_y <= r.pos_y; pos_z <= r.pos_z;
          vel_x <= r.vel_x; vel_y <= r.vel_y; vel_z <= r.vel_z;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result status=%0d hit_time=%h", $time, status, hit_time);
        errors++;
      end else begin
        hit_t e;
        e = expected_hits.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
        if (hit_time !== e.hit_time) begin
          $display("%0t: hit_time expected %h actual %h", $time, e.hit_time, hit_time);
          errors++;
        end
      end
      if ($urandom_range(0, 15) == 0) out_burst <= !out_burst;
      out_stall <= draw_idle(out_burst);
      out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (out_stall > 0) out_stall <= out_stall - 1;
      else out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_rays.size() > 0 || in_valid || expected_hits.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_radius(logic signed [47:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_radius <= value;
    do @(posedge clk); while (!cfg_ready);
    model_radius = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_random(int count);
    repeat (count) pending_rays.push_back(random_ray());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed beats at the reset radius
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, VONE));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, -VONE));
    pending_rays.push_back(make_ray(0, 0, 3 * ONE, 0, 0, -VONE));
    pending_rays.push_back(make_ray(0, 0, -3 * ONE, 0, 0, VONE));
    pending_rays.push_back(make_ray(ONE >>> 1, 0, 2 * ONE, 0, 0, -VONE));
    pending_rays.push_back(make_ray(5 * ONE, 0, 0, 0, 0, VONE));
    pending_rays.push_back(make_ray(0, 0, ONE, VONE, 0, 0));
    pending_rays.push_back(make_ray(PMAX, PMAX, PMAX, VMAX, VMAX, VMAX));
    pending_rays.push_back(make_ray(PMIN, PMIN, PMIN, VMIN, VMIN, VMIN));
    pending_rays.push_back(make_ray(PMAX, 0, PMIN, VMIN, 0, VMAX));
    pending_rays.push_back(make_ray(0, 0, PMAX, 0, 0, 1));
    pending_rays.push_back(make_ray(0, 0, PMIN, 0, 0, -1));
    pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1));
    pending_rays.push_back(make_ray(0, 0, 2 * ONE, 0, 0, 1));
    pending_rays.push_back(make_ray(0, 0, ONE, 0, VMIN, 0));
    push_random(60);

    // once part of the batch is out, hold the sender until the pipeline drains
    while (pending_rays.size() > 40) @(posedge clk);
    hold_rays = 1'b1;
    while (expected_hits.size() > 0 || in_valid) @(posedge clk);
    hold_rays = 1'b0;

    write_radius(-5 * ONE);
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, VONE));
    pending_rays.push_back(make_ray(0, 0, -3 * ONE, 0, 0, VONE));
    push_random(80);
    write_radius(PMAX);
    push_random(50);
    write_radius(PMIN);
    push_random(50);
    write_radius(0);
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, VONE));
    push_random(50);
    write_radius(1);
    push_random(40);
    write_radius($signed(48'($urandom_range(0, 1 << 28))) - (1 << 27));
    push_random(60);
    write_radius(ONE);
    push_random(50);

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
